// File: hw/rtl/fpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants of the binary32 multiplier
// Holds the request and result payload structs, the inter-stage struct and
// the format constants.
// ----------------------------------------------------------------------------
package fpm_pkg;

    localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
    localparam logic [31:0] QUIET_MASK = 32'h0040_0000;
    localparam int          EXP_BIAS   = 127;
    localparam logic [7:0]  EXP_MAX    = 8'hFF;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_fpm_req;

    typedef struct packed {
        logic [31:0] product;
        logic        flag_invalid;
        logic        flag_overflow;
        logic        flag_underflow;
        logic        flag_inexact;
    } t_fpm_res;

    // Unpacked operands handed from the front stage to the multiply stage
    typedef struct packed {
        logic        special;   // result settled by the operand classes
        t_fpm_res    spec_res;
        logic        sign;
        logic [23:0] ma;        // normalised significands
        logic [23:0] mb;
        logic signed [10:0] ez; // biased exponent of the product
    } t_fpm_mid;

    // Leading-zero count of a 24-bit significand (24 when zero)
    function automatic logic [4:0] lzc24(input logic [23:0] m);
        logic [4:0] n;
        logic       hit;
        n   = 5'd24;
        hit = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!hit && m[i]) begin
                n   = 5'(23 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/fpm_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_unpack: operand classification and normalisation
// Settles the zero, infinity and NaN cases and normalises finite operands.
// ----------------------------------------------------------------------------
module fpm_unpack import fpm_pkg::*; (
    input  t_fpm_req i_req,
    output t_fpm_mid o_mid
);
    logic        sa, sb, sg;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        za, zb, ia, ib, na, nb;
    logic [23:0] ma, mb;
    logic [4:0]  la, lb;
    logic signed [10:0] xa, xb;

    assign sa = i_req.operand_a[31];
    assign sb = i_req.operand_b[31];
    assign ea = i_req.operand_a[30:23];
    assign eb = i_req.operand_b[30:23];
    assign fa = i_req.operand_a[22:0];
    assign fb = i_req.operand_b[22:0];
    assign sg = sa ^ sb;
    assign za = (ea == 8'd0) && (fa == 23'd0);
    assign zb = (eb == 8'd0) && (fb == 23'd0);
    assign ia = (ea == EXP_MAX) && (fa == 23'd0);
    assign ib = (eb == EXP_MAX) && (fb == 23'd0);
    assign na = (ea == EXP_MAX) && (fa != 23'd0);
    assign nb = (eb == EXP_MAX) && (fb != 23'd0);

    // Normalise significands; subnormals take the leading-zero shift
    assign ma = {(ea != 8'd0), fa};
    assign mb = {(eb != 8'd0), fb};
    assign la = lzc24(ma);
    assign lb = lzc24(mb);
    assign xa = 11'(signed'({3'd0, ea})) + ((ea == 8'd0) ? 11'sd1 : 11'sd0)
                - 11'(signed'({6'd0, la}));
    assign xb = 11'(signed'({3'd0, eb})) + ((eb == 8'd0) ? 11'sd1 : 11'sd0)
                - 11'(signed'({6'd0, lb}));

    // Special-case result from the operand classes
    always_comb begin
        o_mid          = '0;
        o_mid.sign     = sg;
        o_mid.ma       = ma << la;
        o_mid.mb       = mb << lb;
        o_mid.ez       = xa + xb - 11'(EXP_BIAS);
        o_mid.special  = 1'b1;
        if (na || nb) begin
            o_mid.spec_res.product = {sg, 31'd0} | INF_BITS | QUIET_MASK
                                     | {9'd0, (na ? fa : fb)};
            o_mid.spec_res.flag_invalid = (na && !fa[22]) || (nb && !fb[22]);
        end else if ((za && ib) || (ia && zb)) begin
            o_mid.spec_res.product      = {sg, 31'd0} | QNAN_BITS;
            o_mid.spec_res.flag_invalid = 1'b1;
        end else if (ia || ib) begin
            o_mid.spec_res.product = {sg, 31'd0} | INF_BITS;
        end else if (za || zb) begin
            o_mid.spec_res.product = {sg, 31'd0};
        end else begin
            o_mid.special = 1'b0;
        end
    end

endmodule

// File: hw/rtl/fpm_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_round: product normalisation and rounding
// Takes the registered 48-bit product and forms the rounded binary32 result
// with its flags, including the subnormal and overflow cases.
// ----------------------------------------------------------------------------
module fpm_round import fpm_pkg::*; (
    input  logic               i_sign,
    input  logic [47:0]        i_prod,
    input  logic signed [10:0] i_ez,
    output t_fpm_res           o_res
);
    logic signed [10:0] ez;
    logic [23:0] sig;
    logic [31:0] rest;
    logic [10:0] sh;
    logic [55:0] v, vs;
    logic [23:0] kept;
    logic        rnd, stk;
    logic [31:0] base;

    // Renormalise after the multiply
    always_comb begin
        if (i_prod[47]) begin
            ez   = i_ez + 11'sd1;
            sig  = i_prod[47:24];
            rest = {i_prod[23:0], 8'd0};
        end else begin
            ez   = i_ez;
            sig  = i_prod[46:23];
            rest = {i_prod[22:0], 9'd0};
        end
    end

    // Right shift for tiny results; the shifted value is only used when the
    // shift is at most 24, so five bits of the count are enough
    assign sh = 11'sd1 - ez;
    assign v  = {sig, rest};
    assign vs = v >> sh[4:0];

    always_comb begin
        o_res = '0;
        kept  = '0;
        rnd   = 1'b0;
        stk   = 1'b0;
        base  = '0;
        if (ez >= 11'sd255) begin
            o_res.product       = {i_sign, 31'd0} | INF_BITS;
            o_res.flag_overflow = 1'b1;
            o_res.flag_inexact  = 1'b1;
        end else if (ez <= 11'sd0) begin
            if (sh <= 11'd24) begin
                kept = vs[55:32];
                rnd  = vs[31];
                // Sticky: every bit below the round position
                stk  = (v & ((56'd1 << (6'd31 + {1'b0, sh[4:0]})) - 56'd1)) != 56'd0;
                base = {i_sign, 7'd0, kept};
                o_res.product = base + {31'd0, rnd && (stk || kept[0])};
                o_res.flag_underflow = rnd || stk;
                o_res.flag_inexact   = rnd || stk;
            end else begin
                o_res.product        = {i_sign, 31'd0};
                o_res.flag_underflow = 1'b1;
                o_res.flag_inexact   = 1'b1;
            end
        end else begin
            rnd  = rest[31];
            stk  = rest[30:0] != 31'd0;
            base = {i_sign, ez[7:0], sig[22:0]};
            o_res.product       = base + {31'd0, rnd && (stk || sig[0])};
            o_res.flag_inexact  = rnd || stk;
            o_res.flag_overflow = o_res.product[30:23] == EXP_MAX;
        end
    end

endmodule

// File: hw/rtl/fp32_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_multiplier: binary32 multiply, round to nearest even
// Top level with input register, multiplier and result register.
// ----------------------------------------------------------------------------
// Accepts one request per cycle unless the output stalls. Operands are
// classified and normalised into the input stage register r_mid,
// the 24x24 significand multiply is registered, then rounding feeds the
// result register. The three stages advance together whenever the result
// register is empty or being taken, so a stall on the output holds them all
// and o_ready simply follows that condition. Flags describe only the request
// that produced the result.
module fp32_multiplier import fpm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_fpm_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_fpm_res o_res
);
    t_fpm_mid    n_mid, r_mid;
    logic        r_v1, r_v2, r_v3;
    logic [47:0] r_prod;
    logic        r_sign, r_special;
    logic signed [10:0] r_ez;
    t_fpm_res    r_spec, n_res, r_res, round_res;
    logic        adv;

    assign adv     = !r_v3 || i_ready;
    assign o_ready = adv;

    fpm_unpack u_unpack (.i_req(i_req), .o_mid(n_mid));

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mid     <= n_mid;
            r_prod    <= r_mid.ma * r_mid.mb;
            r_sign    <= r_mid.sign;
            r_ez      <= r_mid.ez;
            r_special <= r_mid.special;
            r_spec    <= r_mid.spec_res;
            r_res     <= n_res;
        end
    end

    fpm_round u_round (.i_sign(r_sign), .i_prod(r_prod), .i_ez(r_ez), .o_res(round_res));

    assign n_res   = r_special ? r_spec : round_res;
    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

// File: hw/rtl/fpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_checker: port-level checks of the multiplier
// Watches the handshakes and result flags on the top-level ports.
// ----------------------------------------------------------------------------
module fpm_checker import fpm_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_ready,
    input logic     o_valid,
    input logic     i_ready,
    input t_fpm_res o_res
);
    // A stalled result holds its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    // Underflow always comes with inexact
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.flag_underflow |-> o_res.flag_inexact)
        else $error("underflow without inexact");

    // Overflow gives infinity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.flag_overflow |-> o_res.product[30:0] == INF_BITS[30:0])
        else $error("overflow without infinity");

    // Space in the output means requests are taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready while empty");
endmodule

bind fp32_multiplier fpm_checker u_fpm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
);
